FILE: rtl/wsc_pkg.sv
package wsc_pkg;

  localparam int MULT_BITS_DEF     = 10;
  localparam int AMP_FRAC_BITS_DEF = 16;
  localparam int MULT_BITS_MAX     = 12;
  localparam int AMP_FRAC_MAX      = 24;
  localparam int Q_FRAC            = 24;
  localparam int SUM_W             = 64;
  localparam int DEN_W             = 3 * SUM_W;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // multiply passes of the final ratio
  localparam logic [1:0] PASS_CP  = 2'd0;  // cross * P
  localparam logic [1:0] PASS_CPP = 2'd1;  // (cross * P) * P
  localparam logic [1:0] PASS_QS  = 2'd2;  // Q * Sn
  localparam logic [1:0] PASS_QSS = 2'd3;  // (Q * Sn) * Sm

  typedef struct packed {
    logic [9:0]  multiplicity;
    logic [15:0] ecc_n;
    logic [15:0] ecc_m;
    logic        last;
  } item_t;

  typedef struct packed {
    logic signed [31:0] cumulant;
    logic [63:0]        weight_total;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic       cap;
    logic       sq;
    logic       w4;
    logic       xp;
    logic       acc;
    logic       mul_load;
    logic       mul_step;
    logic [1:0] pass;
    logic       div_load;
    logic       div_step;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic den_zero;
    logic mul_last;
    logic div_last;
  } stat_t;

endpackage

FILE: rtl/wsc_ctrl.sv
module wsc_ctrl import wsc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_W4   = 4'd2;
  localparam logic [3:0] S_XP   = 4'd3;
  localparam logic [3:0] S_ACC  = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_MLD  = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_DLD  = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0] state, state_next;
  logic [1:0] pass, pass_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    pass_next  = pass;
    cmd        = '0;
    cmd.pass   = pass;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.cap    = 1'b1;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq     = 1'b1;
        state_next = S_W4;
      end
      S_W4: begin
        cmd.w4     = 1'b1;
        state_next = S_XP;
      end
      S_XP: begin
        cmd.xp     = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        pass_next = PASS_CP;
        if (!stat.last) state_next = S_IDLE;
        else if (stat.den_zero) state_next = S_OUT;
        else state_next = S_MLD;
      end
      S_MLD: begin
        cmd.mul_load = 1'b1;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_last) begin
          if (pass == PASS_QSS) begin
            state_next = S_DLD;
          end else begin
            pass_next  = pass + 2'd1;
            state_next = S_MLD;
          end
        end
      end
      S_DLD: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_OUT;
      end
      S_OUT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass  <= PASS_CP;
    end else begin
      state <= state_next;
      pass  <= pass_next;
    end
  end

endmodule

FILE: rtl/wsc_dp.sv
module wsc_dp import wsc_pkg::*; #(
  parameter int MULT_BITS     = MULT_BITS_DEF,
  parameter int AMP_FRAC_BITS = AMP_FRAC_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_we,
  input  logic    cfg_data,
  input  item_t   item,
  input  cmd_t    cmd,
  output stat_t   stat,
  output logic    done,
  output result_t result
);

  localparam int MB     = MULT_BITS;
  localparam int F      = AMP_FRAC_BITS;
  localparam int W2_W   = 2 * MB;
  localparam int W4_W   = 4 * MB;
  localparam int NUM_W  = DEN_W + F + Q_FRAC;
  localparam int DCNT_W = $clog2(NUM_W);
  localparam logic [33:0] QCAP = 34'(64'd1 << 33);

  function automatic logic [SUM_W:0] sat_add(input logic [SUM_W-1:0] a,
                                              input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[SUM_W]) s = {1'b1, {SUM_W{1'b1}}};
    return s;
  endfunction

  logic same_harmonic;

  // event operands
  logic [MB-1:0]   m_r;
  logic [F-1:0]    an_r, am_r;
  logic            last_r;
  logic [W2_W-1:0] w2, t23;
  logic [F-1:0]    sqn, sqm, quad;
  logic [63:0]     w4, pn, pm;
  logic [F+31:0]   pl, ph;

  logic [SUM_W-1:0] sum_p, sum_q, sum_sn, sum_sm, sum_x;
  logic             satf;

  // serial multiplier and divider
  logic [DEN_W-1:0]  mcand, prod, num, den, rem;
  logic [SUM_W-1:0]  mplier;
  logic [5:0]        mcnt;
  logic [NUM_W-1:0]  numsh;
  logic [33:0]       q;
  logic [DCNT_W-1:0] dcnt;

  logic [MULT_BITS_MAX-1:0] m_ext;
  logic [AMP_FRAC_MAX-1:0]  an_ext, am_ext;
  logic [2*F-1:0]           sqn_full, sqm_full, quad_full;
  logic [W4_W-1:0]          w4_full;
  logic [F+2*MB-1:0]        pn_full, pm_full;
  logic [F+63:0]            cp_full;
  logic [SUM_W-1:0]         cp_sat, sm_sel;
  logic                     cp_ovf;
  logic [SUM_W:0]           a_p, a_q, a_sn, a_sm, a_x;
  logic [DEN_W-1:0]         prod_next;
  logic [DEN_W:0]           r2;
  logic                     ge;
  logic [33:0]              q_next;
  logic signed [35:0]       cw;
  logic signed [31:0]       c_sat;

  assign m_ext  = MULT_BITS_MAX'(item.multiplicity);
  assign an_ext = AMP_FRAC_MAX'(item.ecc_n);
  assign am_ext = AMP_FRAC_MAX'(item.ecc_m);

  assign sqn_full  = (2*F)'(an_r) * (2*F)'(an_r);
  assign sqm_full  = (2*F)'(am_r) * (2*F)'(am_r);
  assign quad_full = (2*F)'(sqn) * (2*F)'(sqm);
  assign w4_full   = W4_W'(w2) * W4_W'(t23);
  assign pn_full   = (F+2*MB)'(sqn) * (F+2*MB)'(w2);
  assign pm_full   = (F+2*MB)'(sqm) * (F+2*MB)'(w2);

  assign cp_full = (F+64)'(pl) + ((F+64)'(ph) << 32);
  assign cp_ovf  = |cp_full[F+63:64];
  assign cp_sat  = cp_ovf ? {SUM_W{1'b1}} : cp_full[63:0];

  assign a_p  = sat_add(sum_p, 64'(w2));
  assign a_q  = sat_add(sum_q, w4);
  assign a_sn = sat_add(sum_sn, pn);
  assign a_sm = sat_add(sum_sm, pm);
  assign a_x  = sat_add(sum_x, cp_sat);

  assign sm_sel = same_harmonic ? sum_sn : sum_sm;

  assign prod_next = {prod[DEN_W-2:0], 1'b0} + (mplier[SUM_W-1] ? mcand : '0);

  assign r2     = {rem, numsh[NUM_W-1]};
  assign ge     = (r2 >= {1'b0, den});
  assign q_next = (q >= QCAP) ? QCAP : {q[32:0], ge};

  // R-1 or 2-R in Q8.24, clamped to 32 bits
  always_comb begin
    if (same_harmonic) cw = 36'sd33554432 - $signed({2'b00, q});
    else               cw = $signed({2'b00, q}) - 36'sd16777216;
    if (cw > 36'sd2147483647)       c_sat = 32'sh7FFFFFFF;
    else if (cw < -36'sd2147483648) c_sat = 32'sh80000000;
    else                            c_sat = cw[31:0];
  end

  assign stat.last     = last_r;
  assign stat.den_zero = (sum_q == '0) || (sum_sn == '0) || (sm_sel == '0);
  assign stat.mul_last = (mcnt == '0);
  assign stat.div_last = (dcnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      same_harmonic <= 1'b0;
    end else if (cfg_we) begin
      same_harmonic <= cfg_data;
    end
  end

  // per-event datapath
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      m_r    <= m_ext[MB-1:0];
      an_r   <= an_ext[F-1:0];
      am_r   <= same_harmonic ? an_ext[F-1:0] : am_ext[F-1:0];
      last_r <= item.last;
    end
    if (cmd.sq) begin
      w2  <= W2_W'(m_r) * W2_W'(m_r - MB'(1));
      t23 <= W2_W'(m_r - MB'(2)) * W2_W'(m_r - MB'(3));
      sqn <= sqn_full[2*F-1:F];
      sqm <= sqm_full[2*F-1:F];
    end
    if (cmd.w4) begin
      w4   <= 64'(w4_full);
      quad <= quad_full[2*F-1:F];
      pn   <= 64'(pn_full);
      pm   <= 64'(pm_full);
    end
    if (cmd.xp) begin
      pl <= (F+32)'(quad) * (F+32)'(w4[31:0]);
      ph <= (F+32)'(quad) * (F+32)'(w4[63:32]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      sum_p  <= '0;
      sum_q  <= '0;
      sum_sn <= '0;
      sum_sm <= '0;
      sum_x  <= '0;
      satf   <= 1'b0;
    end else if (cmd.acc) begin
      sum_p  <= a_p[SUM_W-1:0];
      sum_q  <= a_q[SUM_W-1:0];
      sum_sn <= a_sn[SUM_W-1:0];
      sum_sm <= a_sm[SUM_W-1:0];
      sum_x  <= a_x[SUM_W-1:0];
      satf   <= satf | a_p[SUM_W] | a_q[SUM_W] | a_sn[SUM_W] | a_sm[SUM_W]
                | a_x[SUM_W] | cp_ovf;
    end
  end

  // shift-add multiplier, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod <= '0;
      mcnt <= 6'd63;
      case (cmd.pass)
        PASS_CP: begin
          mcand  <= DEN_W'(sum_x);
          mplier <= sum_p;
        end
        PASS_CPP: begin
          mcand  <= num;
          mplier <= sum_p;
        end
        PASS_QS: begin
          mcand  <= DEN_W'(sum_q);
          mplier <= sum_sn;
        end
        PASS_QSS: begin
          mcand  <= den;
          mplier <= sm_sel;
        end
        default: begin
          mcand  <= '0;
          mplier <= '0;
        end
      endcase
    end else if (cmd.mul_step) begin
      prod   <= prod_next;
      mplier <= {mplier[SUM_W-2:0], 1'b0};
      mcnt   <= mcnt - 6'd1;
      if (mcnt == '0) begin
        if (cmd.pass[1]) den <= prod_next;
        else             num <= prod_next;
      end
    end
  end

  // restoring divider, quotient held at the cap
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem   <= '0;
      numsh <= {num, {(F+Q_FRAC){1'b0}}};
      q     <= '0;
      dcnt  <= DCNT_W'(NUM_W - 1);
    end else if (cmd.div_step) begin
      rem   <= ge ? DEN_W'(r2 - {1'b0, den}) : r2[DEN_W-1:0];
      numsh <= {numsh[NUM_W-2:0], 1'b0};
      q     <= q_next;
      dcnt  <= dcnt - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.cumulant     <= stat.den_zero ? 32'sd0 : c_sat;
      result.weight_total <= sum_q;
      result.status       <= satf ? ST_SAT : (stat.den_zero ? ST_ZERO : ST_OK);
    end
  end

endmodule

FILE: rtl/weighted_symmetric_cumulant.sv
// Multiplicity-weighted symmetric cumulant / four-particle cumulant ratio.
//
// Input channel: item (multiplicity, ecc_n, ecc_m, last) is taken when start
// is high and busy is low. Each beat is one event; its weights M(M-1) and
// M(M-1)(M-2)(M-3) and weighted amplitude squares go into saturating sums.
// An event runs through states SQ, W4, XP, ACC and CHK, with busy high throughout.
//
// A beat with last set closes the set. If a denominator sum is zero the
// result is issued straight from the check. Otherwise the ratio runs on a
// shift-add multiplier in 4 passes, then a restoring divider, one quotient
// bit per cycle over 232 + (AMP_FRAC_BITS - 16) bits.
//
// Output channel: done pulses for one cycle with result (cumulant Q8.24,
// weight_total, status). The receiver cannot stall; the result is shown once.
// All sums clear as the result is issued. cfg_we/cfg_data write same_harmonic;
// the user must do so only while idle, as the block does not enforce it.
// Synchronous reset clears sums, mode register and control.
module weighted_symmetric_cumulant import wsc_pkg::*; #(
  parameter int MULT_BITS     = MULT_BITS_DEF,
  parameter int AMP_FRAC_BITS = AMP_FRAC_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  input  logic    cfg_we,
  input  logic    cfg_data,
  output logic    done,
  output result_t result
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: event stages, multiply passes, divide, issue
  wsc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // sums, serial multiplier, divider and result register
  wsc_dp #(
    .MULT_BITS     (MULT_BITS),
    .AMP_FRAC_BITS (AMP_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .item     (item),
    .cmd      (cmd),
    .stat     (stat),
    .done     (done),
    .result   (result)
  );

`ifndef ASSERT_OFF
  // result beat only goes out with the sequencer back at idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");

  // an accepted beat always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accept did not start work");

  // one result per set, never two in a row
  a_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("double result");

  // status code 3 is never issued
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status != 2'd3)) else $error("bad status");
`endif

endmodule
